>>> sv/dpm_pkg.sv
package dpm_pkg;

  // Sizing of the block.
  localparam int MAX_PATTERN = 16;
  localparam int POS_BITS = 32;
  localparam int SYM_BITS = 3;
  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam int FILL_BITS = $clog2(MAX_PATTERN + 1);
  localparam int IDX_BITS = $clog2(MAX_PATTERN);
  localparam int MISS_BITS = 5;
  localparam int PAT_BITS = SYM_BITS * MAX_PATTERN;
  localparam int CFG_DATA_BITS = PAT_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // Base codes.
  localparam logic [SYM_BITS-1:0] BASE_A = 3'd0;
  localparam logic [SYM_BITS-1:0] BASE_C = 3'd1;
  localparam logic [SYM_BITS-1:0] BASE_G = 3'd2;
  localparam logic [SYM_BITS-1:0] BASE_T = 3'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PATTERN_BASES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_MISMATCH_LIMIT = 2'd2,
    CFG_SEARCH_MODE    = 2'd3
  } cfg_reg_t;

  // Input request.
  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    logic                restart;
  } text_t;

  // Result request.
  typedef struct packed {
    logic [POS_BITS-1:0]  offset;
    logic                 strand;
    logic [MISS_BITS-1:0] mismatches;
  } match_t;

  // Configuration as seen by the compare logic.
  typedef struct packed {
    logic [PAT_BITS-1:0] pattern_bases;
    logic [LEN_BITS-1:0] pattern_length;
    logic [MISS_BITS-1:0] mismatch_limit;
    logic                search_mode;
  } cfg_t;

  // One alignment held in the window stage.
  typedef struct packed {
    logic                                valid;
    logic [MAX_PATTERN-1:0][SYM_BITS-1:0] syms;
    logic [FILL_BITS-1:0]                fill;
    logic [POS_BITS-1:0]                 here;
  } align_t;

  // Complement of a base code; N and the other codes map to themselves.
  function automatic logic [SYM_BITS-1:0] complement(input logic [SYM_BITS-1:0] s);
    logic [SYM_BITS-1:0] r;
    case (s)
      BASE_A:  r = BASE_T;
      BASE_C:  r = BASE_G;
      BASE_G:  r = BASE_C;
      BASE_T:  r = BASE_A;
      default: r = s;
    endcase
    return r;
  endfunction

  // Pattern length clamped into 1..MAX_PATTERN.
  function automatic logic [LEN_BITS-1:0] eff_length(input logic [LEN_BITS-1:0] raw);
    logic [LEN_BITS-1:0] r;
    if (raw == '0) begin
      r = LEN_BITS'(1);
    end else if (raw > LEN_BITS'(MAX_PATTERN)) begin
      r = LEN_BITS'(MAX_PATTERN);
    end else begin
      r = raw;
    end
    return r;
  endfunction

endpackage

>>> sv/dpm_cfg_regs.sv
module dpm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dpm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [dpm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output dpm_pkg::cfg_t                       cfg
);

  dpm_pkg::cfg_t regs;

  // Register file, written one register per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern_bases  <= '0;
      regs.pattern_length <= dpm_pkg::LEN_BITS'(1);
      regs.mismatch_limit <= '0;
      regs.search_mode    <= 1'b0;
    end else if (cfg_write) begin
      case (dpm_pkg::cfg_reg_t'(cfg_index))
        dpm_pkg::CFG_PATTERN_BASES:
          regs.pattern_bases <= cfg_data[dpm_pkg::PAT_BITS-1:0];
        dpm_pkg::CFG_PATTERN_LENGTH:
          regs.pattern_length <= cfg_data[dpm_pkg::LEN_BITS-1:0];
        dpm_pkg::CFG_MISMATCH_LIMIT:
          regs.mismatch_limit <= cfg_data[dpm_pkg::MISS_BITS-1:0];
        dpm_pkg::CFG_SEARCH_MODE:
          regs.search_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> sv/dpm_window.sv
module dpm_window (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_stall,
  input  dpm_pkg::text_t   text,
  input  logic             advance,
  output dpm_pkg::align_t  align
);

  logic [dpm_pkg::MAX_PATTERN-1:0][dpm_pkg::SYM_BITS-1:0] window;
  logic [dpm_pkg::FILL_BITS-1:0] fill;
  logic [dpm_pkg::FILL_BITS-1:0] fill_next;
  logic [dpm_pkg::POS_BITS-1:0]  position;
  logic [dpm_pkg::POS_BITS-1:0]  here;
  logic [dpm_pkg::POS_BITS-1:0]  here_next;
  logic                          valid;
  logic                          accept;

  // The held alignment blocks new symbols only while it cannot move on.
  assign text_stall = valid && !advance;
  assign accept     = text_valid && !text_stall;

  // Count and position of the new symbol; a restart begins from zero.
  always_comb begin
    here_next = text.restart ? '0 : position;
    fill_next = text.restart ? '0 : fill;
    if (fill_next < dpm_pkg::FILL_BITS'(dpm_pkg::MAX_PATTERN)) begin
      fill_next = fill_next + dpm_pkg::FILL_BITS'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      fill     <= '0;
      position <= '0;
    end else if (accept) begin
      valid    <= 1'b1;
      fill     <= fill_next;
      position <= here_next + dpm_pkg::POS_BITS'(1);
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // Symbol window, newest at index zero, and the position of the newest symbol.
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= {window[dpm_pkg::MAX_PATTERN-2:0], text.symbol};
      here   <= here_next;
    end
  end

  assign align.valid = valid;
  assign align.syms  = window;
  assign align.fill  = fill;
  assign align.here  = here;

endmodule

>>> sv/dpm_compare.sv
module dpm_compare (
  input  dpm_pkg::cfg_t    cfg,
  input  dpm_pkg::align_t  align,
  output logic             hit,
  output dpm_pkg::match_t  result
);

  logic [dpm_pkg::LEN_BITS-1:0]    len;
  logic [dpm_pkg::MAX_PATTERN-1:0] fwd_miss;
  logic [dpm_pkg::MAX_PATTERN-1:0] rc_differ;
  logic [dpm_pkg::MAX_PATTERN-1:0] rc_miss;
  logic [dpm_pkg::MAX_PATTERN-1:0][dpm_pkg::SYM_BITS-1:0] pat;
  logic [dpm_pkg::MISS_BITS-1:0]   miss;
  logic [dpm_pkg::LEN_BITS-1:0]    mirror;
  logic                            full;

  assign pat  = cfg.pattern_bases;
  assign len  = dpm_pkg::eff_length(cfg.pattern_length);
  assign full = align.fill >= dpm_pkg::FILL_BITS'(len);

  // Per-position compares: window entry k pairs with pattern symbol len-1-k.
  always_comb begin
    for (int k = 0; k < dpm_pkg::MAX_PATTERN; k++) begin
      mirror = len - dpm_pkg::LEN_BITS'(1) - dpm_pkg::LEN_BITS'(k);
      if (dpm_pkg::LEN_BITS'(k) < len) begin
        fwd_miss[k]  = align.syms[k] != pat[mirror[dpm_pkg::IDX_BITS-1:0]];
        rc_differ[k] = dpm_pkg::complement(pat[mirror[dpm_pkg::IDX_BITS-1:0]]) != pat[k];
        rc_miss[k]   = dpm_pkg::complement(pat[k]) != align.syms[k];
      end else begin
        fwd_miss[k]  = 1'b0;
        rc_differ[k] = 1'b0;
        rc_miss[k]   = 1'b0;
      end
    end
  end

  // Mismatch count over the window.
  always_comb begin
    miss = '0;
    for (int k = 0; k < dpm_pkg::MAX_PATTERN; k++) begin
      miss = miss + dpm_pkg::MISS_BITS'(fwd_miss[k]);
    end
  end

  // Accept rules for both modes; forward takes precedence.
  always_comb begin
    result.offset = align.here
                    - dpm_pkg::POS_BITS'(len - dpm_pkg::LEN_BITS'(1));
    result.strand     = 1'b0;
    result.mismatches = miss;
    hit               = 1'b0;
    if (align.valid && full) begin
      if (!cfg.search_mode) begin
        hit = miss <= cfg.mismatch_limit;
      end else if (miss == '0) begin
        hit = 1'b1;
      end else if ((|rc_differ) && !(|rc_miss)) begin
        hit               = 1'b1;
        result.strand     = 1'b1;
        result.mismatches = '0;
      end
    end
  end

endmodule

>>> sv/dna_pattern_matcher.sv
// Streaming DNA pattern matcher. Each accepted text request carries one
// 3-bit base code; once the pattern length worth of symbols of the current
// text has arrived, every symbol closes one alignment, and an accepted
// alignment produces one match request with its start offset, strand and
// mismatch count. The block takes one symbol every clock cycle unless text
// is stalled: the symbol window register feeds a single stage of parallel
// compares and a popcount, whose result is loaded into the output register.
// Text is stalled only while a match is waiting on a stalled output and the
// window stage is occupied. The user must write configuration through
// cfg_write/cfg_index/cfg_data only while no symbol is in flight; the block
// itself does not enforce this.
module dna_pattern_matcher (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [dpm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dpm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               text_valid,
  output logic                               text_stall,
  input  dpm_pkg::text_t                     text,
  output logic                               match_valid,
  input  logic                               match_stall,
  output dpm_pkg::match_t                    match
);

  dpm_pkg::cfg_t   cfg;
  dpm_pkg::align_t align;
  dpm_pkg::match_t result;
  logic            hit;
  logic            advance;

  dpm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpm_window u_window (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .advance    (advance),
    .align      (align)
  );

  dpm_compare u_compare (
    .cfg    (cfg),
    .align  (align),
    .hit    (hit),
    .result (result)
  );

  // Output register takes a new result whenever it is empty or being drained.
  assign advance = !match_valid || !match_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (advance) begin
      match_valid <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      match <= result;
    end
  end

endmodule

>>> sv/dpm_checker.sv
module dpm_checker (
  input logic            clk,
  input logic            rst,
  input logic            text_valid,
  input logic            text_stall,
  input logic            match_valid,
  input logic            match_stall,
  input dpm_pkg::match_t match
);

  // A stalled match holds.
  a_match_hold: assert property (@(posedge clk) disable iff (rst)
    match_valid && match_stall |=> match_valid && $stable(match))
    else $error("match changed while stalled");

  // Text is held back only behind a stalled match.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> match_valid && match_stall)
    else $error("text stalled without a pending match");

  // A fresh match traces back to a symbol accepted into the window register.
  a_match_source: assert property (@(posedge clk) disable iff (rst)
    $rose(match_valid) |-> $past(text_valid && !text_stall, 2))
    else $error("match without a recent symbol");

  // Reverse complement matches are exact.
  a_rc_exact: assert property (@(posedge clk) disable iff (rst)
    match_valid && match.strand |-> match.mismatches == '0)
    else $error("reverse complement match with mismatches");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk)
    rst |=> !match_valid)
    else $error("match valid after reset");

endmodule

bind dna_pattern_matcher dpm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .text_valid  (text_valid),
  .text_stall  (text_stall),
  .match_valid (match_valid),
  .match_stall (match_stall),
  .match       (match)
);

>>> tb/sv/dna_pattern_matcher_monitor.sv
`timescale 1ns / 100ps

module dna_pattern_matcher_monitor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [dpm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dpm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               text_valid,
  input  logic                               text_stall,
  input  dpm_pkg::text_t                     text,
  input  logic                               match_valid,
  input  logic                               match_stall,
  input  dpm_pkg::match_t                    match,
  output int                                 errors,
  output int                                 outstanding
);
  import dpm_pkg::*;

  // Local copy of the configuration registers.
  logic [PAT_BITS-1:0]  pattern_q;
  logic [4:0]           length_q;
  logic [4:0]           limit_q;
  logic                 mode_q;

  // Text history, newest symbol at index 0, and the text position.
  logic [SYM_BITS-1:0]  recent [MAX_PATTERN];
  int                   fill;
  logic [POS_BITS-1:0]  next_pos;

  // Matches predicted but not yet seen on the output.
  match_t               hits_due [$];

  initial errors = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  // Append one predicted match at the back of the queue.
  task automatic add_predicted(input match_t h);
    hits_due = {hits_due, h};
  endtask

  function automatic logic [SYM_BITS-1:0] base_complement(input logic [SYM_BITS-1:0] s);
    logic [SYM_BITS-1:0] r;
    case (s)
      BASE_A:  r = BASE_T;
      BASE_C:  r = BASE_G;
      BASE_G:  r = BASE_C;
      BASE_T:  r = BASE_A;
      default: r = s;
    endcase
    return r;
  endfunction

  // Take one text symbol and test the alignment that ends at it.
  task automatic scan_alignment(input text_t req);
    int span;
    int miss;
    int i;
    logic twin;
    logic rc_hit;
    logic [SYM_BITS-1:0] t;
    logic [SYM_BITS-1:0] p;
    logic [SYM_BITS-1:0] r;
    logic [POS_BITS-1:0] here;
    match_t hit;

    if (req.restart) begin
      fill = 0;
      next_pos = '0;
    end
    for (i = MAX_PATTERN - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = req.symbol;
    if (fill < MAX_PATTERN) fill++;
    here = next_pos;
    next_pos = next_pos + 1'b1;

    span = (length_q == 0) ? 1 : (length_q > MAX_PATTERN) ? MAX_PATTERN : int'(length_q);
    if (fill < span) return;

    // Count forward mismatches and compare against the reverse complement.
    miss = 0;
    twin = 1'b1;
    rc_hit = 1'b1;
    for (i = 0; i < span; i++) begin
      t = recent[span-1-i];
      p = pattern_q[SYM_BITS*i +: SYM_BITS];
      r = base_complement(pattern_q[SYM_BITS*(span-1-i) +: SYM_BITS]);
      if (t != p) miss++;
      if (r != p) twin = 1'b0;
      if (r != t) rc_hit = 1'b0;
    end

    hit.offset = here - POS_BITS'(span - 1);
    hit.strand = 1'b0;
    hit.mismatches = MISS_BITS'(miss);
    if (!mode_q) begin
      if (miss <= int'(limit_q)) add_predicted(hit);
    end else if (miss == 0) begin
      add_predicted(hit);
    end else if (!twin && rc_hit) begin
      hit.strand = 1'b1;
      hit.mismatches = '0;
      add_predicted(hit);
    end
  endtask

  // Follow configuration writes, check matches and predict from text requests.
  always @(posedge clk) begin
    match_t want;
    if (rst) begin
      pattern_q = '0;
      length_q = 5'd1;
      limit_q = '0;
      mode_q = 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) recent[k] = '0;
      fill = 0;
      next_pos = '0;
      hits_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PATTERN_BASES:  pattern_q = cfg_data[PAT_BITS-1:0];
          CFG_PATTERN_LENGTH: length_q = cfg_data[4:0];
          CFG_MISMATCH_LIMIT: limit_q = cfg_data[4:0];
          CFG_SEARCH_MODE:    mode_q = cfg_data[0];
          default: ;
        endcase
      end
      if (match_valid && !match_stall) begin
        if (hits_due.size() == 0) begin
          report_mismatch($sformatf("match at offset %0d with none predicted", match.offset));
        end else begin
          want = hits_due.pop_front();
          if (match.offset != want.offset)
            report_mismatch($sformatf("offset %0d, predicted %0d", match.offset, want.offset));
          if (match.strand != want.strand)
            report_mismatch($sformatf("strand %0d at offset %0d, predicted %0d",
                                      match.strand, want.offset, want.strand));
          if (match.mismatches != want.mismatches)
            report_mismatch($sformatf("mismatches %0d at offset %0d, predicted %0d",
                                      match.mismatches, want.offset, want.mismatches));
        end
      end
      if (text_valid && !text_stall) scan_alignment(text);
    end
    outstanding = hits_due.size();
  end

endmodule

>>> tb/sv/dna_pattern_matcher_test.sv
`timescale 1ns / 100ps

module dna_pattern_matcher_test;
  import dpm_pkg::*;

  // Base codes the package does not name.
  localparam logic [SYM_BITS-1:0] BASE_N  = 3'd4;
  localparam logic [SYM_BITS-1:0] BASE_X5 = 3'd5;
  localparam logic [SYM_BITS-1:0] BASE_X6 = 3'd6;
  localparam logic [SYM_BITS-1:0] BASE_X7 = 3'd7;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      text_valid;
  logic                      text_stall;
  text_t                     text;
  logic                      match_valid;
  logic                      match_stall;
  match_t                    match;

  int                        errors;
  int                        pending;
  int                        idle_max;
  int                        text_count;
  logic [PAT_BITS-1:0]       cur_pattern;
  int                        cur_span;

  dna_pattern_matcher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text),
    .match_valid (match_valid),
    .match_stall (match_stall),
    .match       (match)
  );

  dna_pattern_matcher_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text),
    .match_valid (match_valid),
    .match_stall (match_stall),
    .match       (match),
    .errors      (errors),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #4_000_000;
    $display("dna_pattern_matcher: mismatch");
    $finish;
  end

  function automatic int idle_pick();
    return (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
  endfunction

  // Mostly real bases, now and then N or one of the other codes.
  function automatic logic [SYM_BITS-1:0] random_base();
    if ($urandom_range(0, 11) < 10) return SYM_BITS'($urandom_range(BASE_A, BASE_T));
    return SYM_BITS'($urandom_range(BASE_N, BASE_X7));
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  // Write all four registers; unused upper data bits carry noise.
  task automatic set_config(input logic [PAT_BITS-1:0] bases, input logic [4:0] length,
                            input logic [4:0] limit, input logic mode);
    write_reg(CFG_PATTERN_BASES, bases);
    write_reg(CFG_PATTERN_LENGTH, {$urandom(), 11'($urandom()), length});
    write_reg(CFG_MISMATCH_LIMIT, {$urandom(), 11'($urandom()), limit});
    write_reg(CFG_SEARCH_MODE, {$urandom(), 15'($urandom()), mode});
    cfg_write <= 1'b0;
    cur_pattern = bases;
    cur_span = (length == 0) ? 1 : (length > MAX_PATTERN) ? MAX_PATTERN : int'(length);
  endtask

  // Send one text request after a random gap and wait until it is taken.
  task automatic send_text(input logic [SYM_BITS-1:0] sym, input logic fresh);
    int gap;
    gap = idle_pick();
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_valid <= 1'b1;
    text <= {sym, fresh};
    do @(posedge clk); while (text_stall);
    @(negedge clk);
    text_count++;
  endtask

  // Hold text until every predicted match is out and the pipeline has drained.
  task automatic settle();
    text_valid <= 1'b0;
    wait (pending == 0);
    repeat (6) @(negedge clk);
  endtask

  // A noisy copy of the pattern or its reverse complement, or plain noise.
  task automatic feed_burst();
    int count;
    logic flip;
    logic fresh;
    logic [SYM_BITS-1:0] s;
    fresh = ($urandom_range(0, 29) == 0);
    if ($urandom_range(0, 9) < 6) begin
      flip = 1'($urandom_range(0, 1));
      for (int j = 0; j < cur_span; j++) begin
        if (flip) begin
          s = cur_pattern[SYM_BITS*(cur_span-1-j) +: SYM_BITS];
          if (s <= BASE_T) s = BASE_T - s;
        end else begin
          s = cur_pattern[SYM_BITS*j +: SYM_BITS];
        end
        if ($urandom_range(0, 7) == 0) s = random_base();
        send_text(s, fresh && j == 0);
      end
    end else begin
      count = $urandom_range(1, cur_span);
      for (int j = 0; j < count; j++) send_text(random_base(), fresh && j == 0);
    end
  endtask

  // Match receiver: stall a random number of cycles before each request.
  initial begin
    int hold;
    match_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = idle_pick();
      if (hold > 0) begin
        match_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      match_stall <= 1'b0;
      do @(posedge clk); while (!match_valid);
      @(negedge clk);
    end
  end

  // Text stimulus and final verdict.
  initial begin
    int target;
    int span;
    logic [PAT_BITS-1:0] bases;
    logic [4:0] length;
    logic [4:0] limit;
    logic mode;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_PATTERN_BASES;
    cfg_data = '0;
    text_valid = 1'b0;
    text = '0;
    idle_max = 0;
    text_count = 0;
    cur_pattern = '0;
    cur_span = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Forward ACGT, exact only: a hit, a near miss, and a restart mid-text.
    set_config({36'd0, BASE_T, BASE_G, BASE_C, BASE_A}, 5'd4, 5'd0, 1'b0);
    send_text(BASE_A, 1'b1);
    send_text(BASE_C, 1'b0);
    send_text(BASE_G, 1'b0);
    send_text(BASE_T, 1'b0);
    send_text(BASE_A, 1'b0);
    send_text(BASE_C, 1'b0);
    send_text(BASE_G, 1'b0);
    send_text(BASE_A, 1'b0);
    send_text(BASE_T, 1'b1);
    settle();

    // Both strands: ACC reads GGT on the other strand.
    set_config({39'd0, BASE_C, BASE_C, BASE_A}, 5'd3, 5'd0, 1'b1);
    send_text(BASE_G, 1'b1);
    send_text(BASE_G, 1'b0);
    send_text(BASE_T, 1'b0);
    send_text(BASE_A, 1'b0);
    send_text(BASE_C, 1'b0);
    send_text(BASE_C, 1'b0);
    settle();

    // A palindromic pattern must report the forward strand only.
    set_config({36'd0, BASE_T, BASE_G, BASE_C, BASE_A}, 5'd4, 5'd0, 1'b1);
    send_text(BASE_A, 1'b1);
    send_text(BASE_C, 1'b0);
    send_text(BASE_G, 1'b0);
    send_text(BASE_T, 1'b0);
    settle();

    // Length zero acts as one, and a limit above the length accepts everything.
    set_config('1, 5'd0, 5'd31, 1'b0);
    send_text(BASE_X7, 1'b1);
    send_text(BASE_X5, 1'b0);
    send_text(BASE_X6, 1'b0);
    send_text(BASE_N, 1'b0);

    // Random phases, the first two at the register extremes.
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      if (phase == 0) begin
        bases = '1;
        length = 5'd31;
        limit = 5'd16;
        mode = 1'b0;
      end else if (phase == 1) begin
        bases = '0;
        length = 5'd16;
        limit = 5'd0;
        mode = 1'b1;
      end else begin
        for (int j = 0; j < MAX_PATTERN; j++) bases[SYM_BITS*j +: SYM_BITS] = random_base();
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
        length = 5'(span);
        limit = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, span / 3));
        mode = 1'($urandom_range(0, 1));
      end
      set_config(bases, length, limit, mode);
      idle_max = (phase % 3 == 0) ? 0 : 7;
      target = text_count + 180;
      while (text_count < target) begin
        if ($urandom_range(0, 19) == 0) idle_max = 7 - idle_max;
        if ($urandom_range(0, 149) == 0) settle();
        feed_burst();
      end
    end

    text_valid <= 1'b0;
    wait (pending == 0);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("dna_pattern_matcher: match");
    end else begin
      $display("dna_pattern_matcher: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dpm_pkg.sv
sv/dpm_cfg_regs.sv
sv/dpm_window.sv
sv/dpm_compare.sv
sv/dna_pattern_matcher.sv
sv/dpm_checker.sv
tb/sv/dna_pattern_matcher_monitor.sv
tb/sv/dna_pattern_matcher_test.sv
